>>> sv/qdec_pkg.sv
package qdec_pkg;

   localparam int COUNT_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int ACC_BITS      = 128;
   localparam int QUOT_BITS     = 80;
   localparam int DIVISOR_BITS  = 34;
   localparam int LIMB_BITS     = 32;
   localparam int VALUE_BITS    = 48;

   localparam logic [31:0] TWO_PI_Q29    = 32'd3373259426;
   localparam logic [31:0] RPM_FACTOR    = 32'd60000;
   localparam logic [31:0] DEG_FACTOR    = 32'd360;
   localparam logic [31:0] MILLI_FACTOR  = 32'd1000;
   localparam logic [6:0]  DIV_LAST_BIT  = 7'(QUOT_BITS - 1);

   // request operation codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // unit modes
   localparam logic [1:0] MODE_DEG   = 2'd0;
   localparam logic [1:0] MODE_RAD   = 2'd1;
   localparam logic [1:0] MODE_METRE = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   // register indexes
   localparam logic [1:0] REG_PPR    = 2'd0;
   localparam logic [1:0] REG_PERIOD = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;
   localparam logic [1:0] REG_MODE   = 2'd3;

   typedef enum logic [1:0] {
      FAC_BASE,
      FAC_MILLI,
      FAC_TWO_PI,
      FAC_RADIUS
   } factor_type;

   typedef struct packed {
      logic [15:0] pulses_per_rev;
      logic [15:0] sample_period_ms;
      logic [31:0] wheel_radius;
      logic [1:0]  unit_mode;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       job_speed;
      logic       mul_step;
      logic       mul_first;
      logic [1:0] limb;
      factor_type factor;
      logic       shift;
      logic       div_step;
      logic       store;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic       closed;
      logic [1:0] unit_mode;
      logic       out_free;
   } status_type;

endpackage

>>> sv/qdec_ctrl.sv
module qdec_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  qdec_pkg::status_type  stat,
   output qdec_pkg::cmd_type     cmd,
   output logic                  idle
);
   import qdec_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_LOAD,
      ST_MUL,
      ST_SHIFT,
      ST_DIV,
      ST_STORE,
      ST_DONE
   } state_type;

   state_type  state_ff;
   logic       job_ff;
   logic [1:0] step_ff;
   logic [1:0] limb_ff;
   logic [6:0] bit_ff;
   logic [1:0] last_step;
   logic       scaled_mode;

   assign scaled_mode = (stat.unit_mode == MODE_RAD) || (stat.unit_mode == MODE_METRE);
   assign last_step   = (stat.unit_mode == MODE_METRE) ? 2'd2 :
                        (stat.unit_mode == MODE_RAD)   ? 2'd1 : 2'd0;

   // factor chain selection
   always_comb begin
      cmd = '0;
      cmd.factor = FAC_BASE;
      if (scaled_mode) begin
         case (step_ff)
            2'd0:    cmd.factor = FAC_MILLI;
            2'd1:    cmd.factor = FAC_TWO_PI;
            2'd2:    cmd.factor = FAC_RADIUS;
            default: cmd.factor = FAC_BASE;
         endcase
      end
      cmd.accept    = (state_ff == ST_IDLE) && stat.req_valid;
      cmd.load      = (state_ff == ST_LOAD);
      cmd.job_speed = job_ff;
      cmd.mul_step  = (state_ff == ST_MUL);
      cmd.mul_first = (limb_ff == 2'd0);
      cmd.limb      = limb_ff;
      cmd.shift     = (state_ff == ST_SHIFT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.store     = (state_ff == ST_STORE);
      cmd.emit      = (state_ff == ST_DONE) && stat.out_free;
   end

   assign idle = (state_ff == ST_IDLE);

   // sequencer: speed job first on a closing tick, then position
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= 1'b0;
         step_ff  <= 2'd0;
         limb_ff  <= 2'd0;
         bit_ff   <= 7'd0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (stat.req_valid) state_ff <= ST_START;
            end
            ST_START: begin
               job_ff   <= stat.closed;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               step_ff  <= (scaled_mode && !job_ff) ? 2'd1 : 2'd0;
               limb_ff  <= 2'd0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               limb_ff <= limb_ff + 2'd1;
               if (limb_ff == 2'd3) begin
                  if (step_ff == last_step) state_ff <= ST_SHIFT;
                  else step_ff <= step_ff + 2'd1;
               end
            end
            ST_SHIFT: begin
               bit_ff   <= 7'd0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               bit_ff <= bit_ff + 7'd1;
               if (bit_ff == DIV_LAST_BIT) state_ff <= ST_STORE;
            end
            ST_STORE: begin
               if (job_ff) begin
                  job_ff   <= 1'b0;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (stat.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/qdec_dp.sv
module qdec_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  qdec_pkg::cmd_type    cmd,
   input  qdec_pkg::cfg_type    cfg,
   input  logic [1:0]           op,
   input  logic                 pin_a,
   input  logic                 pin_b,
   output logic                 closed,
   output logic [31:0]          count,
   output logic [47:0]          position,
   output logic [47:0]          speed
);
   import qdec_pkg::*;

   logic [1:0]              phases_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   start_ff;
   logic [15:0]             elapsed_ff;
   logic [47:0]             held_ff;
   logic [47:0]             pos_ff;
   logic                    closed_ff;
   logic [COUNT_BITS-1:0]   delta_ff;
   logic [15:0]             window_ff;
   logic                    job_ff;
   logic                    neg_ff;
   logic [ACC_BITS-1:0]     acc_ff;
   logic [LIMB_BITS-1:0]    carry_ff;
   logic [DIVISOR_BITS-1:0] divisor_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;

   logic [1:0]              cur_phases;
   logic [1:0]              diff;
   logic [15:0]             elapsed_inc;
   logic                    close_now;
   logic [COUNT_BITS-1:0]   value;
   logic [COUNT_BITS-1:0]   mag;
   logic [15:0]             ppr_eff;
   logic [17:0]             dvalue;
   logic [15:0]             tvalue;
   logic [31:0]             factor;
   logic [63:0]             prod;
   logic [DIVISOR_BITS:0]   trial;
   logic                    qbit;
   logic [QUOT_BITS-1:0]    quot;
   logic [QUOT_BITS-1:0]    lim;
   logic [47:0]             sat;
   logic [47:0]             result;

   // pin decode and window timing
   assign cur_phases  = {pin_a, pin_b};
   assign diff        = cur_phases ^ phases_ff;
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign close_now   = (op == OP_TICK) && (elapsed_inc >= cfg.sample_period_ms);

   // operand magnitude and divisor
   assign value   = cmd.job_speed ? delta_ff : count_ff;
   assign mag     = value[COUNT_BITS-1] ? (~value + COUNT_BITS'(1)) : value;
   assign ppr_eff = (cfg.pulses_per_rev == 16'd0) ? 16'd1 : cfg.pulses_per_rev;
   assign dvalue  = {ppr_eff, 2'b00};
   assign tvalue  = cmd.job_speed ? window_ff : 16'd1;

   // factor for the current multiply pass
   always_comb begin
      case (cmd.factor)
         FAC_BASE:   factor = job_ff ? RPM_FACTOR : DEG_FACTOR;
         FAC_MILLI:  factor = MILLI_FACTOR;
         FAC_TWO_PI: factor = TWO_PI_Q29;
         FAC_RADIUS: factor = cfg.wheel_radius;
         default:    factor = DEG_FACTOR;
      endcase
   end

   // one limb times the factor per cycle
   assign prod = acc_ff[{cmd.limb, 5'd0} +: LIMB_BITS] * factor
               + {32'd0, (cmd.mul_first ? 32'd0 : carry_ff)};

   // restoring divide step
   assign trial = {rem_ff, acc_ff[QUOT_BITS-1]};
   assign qbit  = (trial >= {1'b0, divisor_ff});

   // saturate and sign
   assign quot = acc_ff[QUOT_BITS-1:0];
   assign lim  = neg_ff ? (QUOT_BITS'(1) << 47) : ((QUOT_BITS'(1) << 47) - QUOT_BITS'(1));
   assign sat  = (quot > lim) ? lim[47:0] : quot[47:0];
   assign result = (cfg.unit_mode == MODE_NONE) ? 48'd0 :
                   neg_ff ? (~sat + 48'd1) : sat;

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         phases_ff  <= 2'd0;
         count_ff   <= '0;
         start_ff   <= '0;
         elapsed_ff <= 16'd0;
         held_ff    <= 48'd0;
         closed_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            closed_ff <= close_now;
            case (op)
               OP_SAMPLE: begin
                  phases_ff <= cur_phases;
                  if (diff == 2'b01 || diff == 2'b10) begin
                     if (phases_ff[0] ^ cur_phases[1]) count_ff <= count_ff - COUNT_BITS'(1);
                     else count_ff <= count_ff + COUNT_BITS'(1);
                  end
               end
               OP_TICK: begin
                  if (close_now) begin
                     start_ff   <= count_ff;
                     elapsed_ff <= 16'd0;
                  end else begin
                     elapsed_ff <= elapsed_inc;
                  end
               end
               OP_CLEAR: begin
                  count_ff <= '0;
                  start_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.store && job_ff) held_ff <= result;
      end
   end

   // arithmetic unit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         delta_ff  <= count_ff - start_ff;
         window_ff <= elapsed_inc;
      end
      if (cmd.load) begin
         job_ff     <= cmd.job_speed;
         neg_ff     <= value[COUNT_BITS-1];
         acc_ff     <= {{(ACC_BITS-COUNT_BITS){1'b0}}, mag};
         divisor_ff <= dvalue * tvalue;
      end
      if (cmd.mul_step) begin
         acc_ff[{cmd.limb, 5'd0} +: LIMB_BITS] <= prod[31:0];
         carry_ff <= prod[63:32];
      end
      if (cmd.shift) begin
         rem_ff <= '0;
         case (cfg.unit_mode)
            MODE_RAD:   acc_ff <= acc_ff >> (29 - FRACTION_BITS);
            MODE_METRE: acc_ff <= acc_ff >> (45 - FRACTION_BITS);
            default:    acc_ff <= acc_ff << FRACTION_BITS;
         endcase
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? DIVISOR_BITS'(trial - {1'b0, divisor_ff})
                        : trial[DIVISOR_BITS-1:0];
         acc_ff[QUOT_BITS-1:0] <= {acc_ff[QUOT_BITS-2:0], qbit};
      end
      if (cmd.store && !job_ff) pos_ff <= result;
   end

   assign closed   = closed_ff;
   assign count    = count_ff;
   assign position = pos_ff;
   assign speed    = held_ff;

   // remainder stays below the divisor throughout a division
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

   // clear zeroes the count and the window start
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && op == OP_CLEAR) |=> (count_ff == '0 && start_ff == '0))
      else $error("clear did not zero count");

   // a closing tick restarts the window
   a_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && close_now) |=> (elapsed_ff == 16'd0 && closed_ff))
      else $error("closing tick did not restart window");

endmodule

>>> sv/quadrature_decoder_speed_position.sv
// X4 quadrature decoder with position and windowed speed. Each request (op on req_tuser:
// 0 pin sample, 1 millisecond tick, 2 clear, 3 no operation) yields one response with the
// signed edge count, the position and the held speed in Q31.16 of the unit set by
// unit_mode, with rsp_tuser set when a tick closed a speed window. Requests are handled
// one at a time by a shared multiply and divide unit: a 32x32 multiplier works one 32 bit
// limb per cycle (one to three factors) and a restoring divider yields one quotient bit
// per cycle. A tick that closes a window first runs a speed pass, then the position pass.
// A finished response waits in the output register while the next request is taken.
module quadrature_decoder_speed_position (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // pin_a[0], pin_b[1], zero fill
   input  logic [1:0]   req_tuser,   // op[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // count[31:0], position[79:32], speed[127:80]
   output logic         rsp_tuser,   // speed_updated[0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import qdec_pkg::*;

   cfg_type    cfg_ff;
   status_type stat;
   cmd_type    cmd;
   logic       idle;
   logic       closed;
   logic [31:0] count;
   logic [47:0] position;
   logic [47:0] speed;
   logic        rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic         rsp_user_ff;
   logic         out_free;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulses_per_rev   <= 16'd1024;
         cfg_ff.sample_period_ms <= 16'd100;
         cfg_ff.wheel_radius     <= 32'd65536;
         cfg_ff.unit_mode        <= MODE_DEG;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            REG_PPR:    cfg_ff.pulses_per_rev   <= csr_pwdata[15:0];
            REG_PERIOD: cfg_ff.sample_period_ms <= csr_pwdata[15:0];
            REG_RADIUS: cfg_ff.wheel_radius     <= csr_pwdata;
            REG_MODE:   cfg_ff.unit_mode        <= csr_pwdata[1:0];
            default:    cfg_ff.unit_mode        <= cfg_ff.unit_mode;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PPR:    csr_prdata = {16'd0, cfg_ff.pulses_per_rev};
         REG_PERIOD: csr_prdata = {16'd0, cfg_ff.sample_period_ms};
         REG_RADIUS: csr_prdata = cfg_ff.wheel_radius;
         REG_MODE:   csr_prdata = {30'd0, cfg_ff.unit_mode};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // controller status
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign stat.req_valid = req_tvalid;
   assign stat.closed    = closed;
   assign stat.unit_mode = cfg_ff.unit_mode;
   assign stat.out_free  = out_free;
   assign req_tready     = idle;

   qdec_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd),
      .idle  (idle)
   );

   qdec_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .op       (req_tuser),
      .pin_a    (req_tdata[0]),
      .pin_b    (req_tdata[1]),
      .closed   (closed),
      .count    (count),
      .position (position),
      .speed    (speed)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {speed, position, count};
         rsp_user_ff <= closed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
